// File: rtl/core/spq_pkg.sv
package spq_pkg;

  // Default sizing
  localparam int SPQ_DEPTH         = 16;
  localparam int SPQ_PAYLOAD_BITS  = 16;
  localparam int SPQ_PRIORITY_BITS = 8;

  // Capacity limit register
  localparam int          LIMIT_W     = 5;
  localparam logic [4:0]  LIMIT_RESET = 5'd16;

  // Result status codes
  localparam int          STATUS_W     = 2;
  localparam logic [1:0]  STATUS_OK    = 2'd0;
  localparam logic [1:0]  STATUS_FULL  = 2'd1;
  localparam logic [1:0]  STATUS_EMPTY = 2'd2;

  // Operation codes
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

endpackage

// File: rtl/core/spq_store.sv
// Entry memory addressed by logical slot: slot 0 is the entry at the head
// pointer, slots wrap around the end of the array.
module spq_store #(
  parameter int  DEPTH = 16,
  parameter int  WIDTH = 24,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic [IDX_W-1:0] head,
  input  logic [IDX_W-1:0] rd_idx,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;

  // Logical to physical slot: one add, one compare and subtract
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                            input logic [IDX_W-1:0] idx);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, idx};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign rd_addr = phys(head, rd_idx);
  assign wr_addr = phys(head, wr_idx);

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/sorted_array_priority_queue.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_mode, in_payload, in_priority_req
// out      output     out_valid / out_ready  out_status, out_payload, out_priority
// cfg      input      cfg_valid / cfg_ready  cfg_data (capacity limit)
//
// Full and empty items need no memory access. A dequeue reads the front entry
// from the entry memory and registers it. An enqueue moves entries back one
// slot per cycle through the single read and write port until the insert
// point is found. Reset (synchronous, rst_n low) empties the queue and sets
// the limit to 16; no memory clearing pass. A new item is taken only in idle
// with the output register free or being drained; cfg is always ready.
module sorted_array_priority_queue #(
  parameter int DEPTH         = spq_pkg::SPQ_DEPTH,
  parameter int PAYLOAD_BITS  = spq_pkg::SPQ_PAYLOAD_BITS,
  parameter int PRIORITY_BITS = spq_pkg::SPQ_PRIORITY_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_mode,
  input  logic [PAYLOAD_BITS-1:0]     in_payload,
  input  logic [PRIORITY_BITS-1:0]    in_priority_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [spq_pkg::STATUS_W-1:0] out_status,
  output logic [PAYLOAD_BITS-1:0]     out_payload,
  output logic [PRIORITY_BITS-1:0]    out_priority,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [spq_pkg::LIMIT_W-1:0] cfg_data
);
  import spq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int ENT_W = PRIORITY_BITS + PAYLOAD_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INS  = 2'd1;
  localparam logic [1:0] ST_DEQ  = 2'd2;

  // Control state
  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [LIMIT_W-1:0]  limit_r, limit_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Payload registers
  logic [IDX_W-1:0]          ins_idx_r, ins_idx_nxt;
  logic [PAYLOAD_BITS-1:0]   pay_r, pay_nxt;
  logic [PRIORITY_BITS-1:0]  pri_r, pri_nxt;
  logic [STATUS_W-1:0]       status_r, status_nxt;
  logic [PAYLOAD_BITS-1:0]   opay_r, opay_nxt;
  logic [PRIORITY_BITS-1:0]  opri_r, opri_nxt;

  logic                in_fire;
  logic                out_fire;
  logic                full;
  logic [IDX_W-1:0]    rd_idx;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;
  logic [ENT_W-1:0]    wr_data;
  logic [ENT_W-1:0]    rd_data;
  logic [PRIORITY_BITS-1:0] rd_pri;
  logic [PAYLOAD_BITS-1:0]  rd_pay;

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign cfg_ready = 1'b1;

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_payload  = opay_r;
  assign out_priority = opri_r;

  assign rd_pri = rd_data[ENT_W-1:PAYLOAD_BITS];
  assign rd_pay = rd_data[PAYLOAD_BITS-1:0];

  // Full when count reaches the limit, the limit saturating at DEPTH
  assign full = (CMP_W'(count_r) >= CMP_W'(limit_r)) || (count_r >= CNT_W'(DEPTH));

  // Read address: back entry on enqueue accept, front on dequeue accept,
  // two slots ahead of the insert point while shifting
  always_comb begin
    if (state_r == ST_INS) begin
      rd_idx = ins_idx_r - IDX_W'(2);
    end else if (in_mode == MODE_DEQ) begin
      rd_idx = '0;
    end else begin
      rd_idx = IDX_W'(count_r - CNT_W'(1));
    end
  end

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    limit_nxt     = limit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ins_idx_nxt   = ins_idx_r;
    pay_nxt       = pay_r;
    pri_nxt       = pri_r;
    status_nxt    = status_r;
    opay_nxt      = opay_r;
    opri_nxt      = opri_r;
    wr_en         = 1'b0;
    wr_idx        = ins_idx_r;
    wr_data       = {pri_r, pay_r};

    if (cfg_valid && cfg_ready) begin
      limit_nxt = cfg_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          opay_nxt = '0;
          opri_nxt = '0;
          if (in_mode == MODE_ENQ) begin
            out_valid_nxt = 1'b1;
            if (full) begin
              status_nxt = STATUS_FULL;
            end else begin
              status_nxt  = STATUS_OK;
              pay_nxt     = in_payload;
              pri_nxt     = in_priority_req;
              ins_idx_nxt = IDX_W'(count_r);
              count_nxt   = count_r + CNT_W'(1);
              state_nxt   = ST_INS;
            end
          end else begin
            if (count_r == '0) begin
              out_valid_nxt = 1'b1;
              status_nxt    = STATUS_EMPTY;
            end else begin
              count_nxt = count_r - CNT_W'(1);
              head_nxt  = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
              state_nxt = ST_DEQ;
            end
          end
        end
      end

      // One slot per cycle: move the entry ahead back, or drop the new one in
      ST_INS: begin
        wr_en = 1'b1;
        if (ins_idx_r == '0 || rd_pri >= pri_r) begin
          state_nxt = ST_IDLE;
        end else begin
          wr_data     = rd_data;
          ins_idx_nxt = ins_idx_r - IDX_W'(1);
        end
      end

      // Front entry arrives from memory
      ST_DEQ: begin
        out_valid_nxt = 1'b1;
        status_nxt    = STATUS_OK;
        opay_nxt      = rd_pay;
        opri_nxt      = rd_pri;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ins_idx_r <= ins_idx_nxt;
    pay_r     <= pay_nxt;
    pri_r     <= pri_nxt;
    status_r  <= status_nxt;
    opay_r    <= opay_nxt;
    opri_r    <= opri_nxt;
  end

  spq_store #(
    .DEPTH (DEPTH),
    .WIDTH (ENT_W)
  ) u_store (
    .clk     (clk),
    .head    (head_r),
    .rd_idx  (rd_idx),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // Count never exceeds the array
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // Insert point stays inside the stored entries
  a_ins_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS) |-> (CNT_W'(ins_idx_r) < count_r))
    else $error("insert index out of range");

  // Successful dequeue transfer reads memory, then presents the entry
  a_deq_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_mode == MODE_DEQ && count_r != '0)
      |=> (state_r == ST_DEQ) ##1 (out_valid_r && status_r == STATUS_OK))
    else $error("dequeue did not deliver front entry");

  // Enqueue result is posted right after the transfer
  a_enq_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_mode == MODE_ENQ)
      |=> (out_valid_r && opay_r == '0 && opri_r == '0
           && (status_r == STATUS_OK || status_r == STATUS_FULL)))
    else $error("enqueue result missing");

endmodule
